### hdl/dle_stx_etx_packet_deframer_top_macros.svh
// Assertion helpers for the deframer. Bodies vanish when SYNTHESIS is set.
`ifndef DLE_STX_ETX_PACKET_DEFRAMER_TOP_MACROS_SVH
`define DLE_STX_ETX_PACKET_DEFRAMER_TOP_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication
`define DLE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("deframer assertion failed");

// Next-cycle implication
`define DLE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("deframer assertion failed");

`else

`define DLE_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define DLE_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

### hdl/dle_dfr_pkg.sv
`timescale 1ns / 1ps

package dle_dfr_pkg;

    typedef enum logic [3:0] {
        PH_IDLE = 4'd0,
        PH_HUNT = 4'd1,
        PH_ADDR = 4'd2,
        PH_CMD  = 4'd3,
        PH_KEY  = 4'd4,
        PH_LENH = 4'd5,
        PH_LENL = 4'd6,
        PH_DATA = 4'd7,
        PH_CRCL = 4'd8,
        PH_CRCH = 4'd9,
        PH_END  = 4'd10,
        PH_DONE = 4'd11
    } t_phase;

    typedef enum logic [2:0] {
        EV_NONE     = 3'd0,
        EV_STORED   = 3'd1,
        EV_GOOD     = 3'd2,
        EV_LONG     = 3'd3,
        EV_CRC      = 3'd4,
        EV_NOEND    = 3'd5,
        EV_BADSTATE = 3'd6,
        EV_READ     = 3'd7
    } t_event;

    typedef enum logic [1:0] {
        REQ_BYTE  = 2'd0,
        REQ_REARM = 2'd1,
        REQ_READ  = 2'd2,
        REQ_NOP   = 2'd3
    } t_req;

    // Configuration register indexes
    localparam logic [2:0] CFG_START_CODE  = 3'd0;
    localparam logic [2:0] CFG_END_CODE    = 3'd1;
    localparam logic [2:0] CFG_ESCAPE_CODE = 3'd2;
    localparam logic [2:0] CFG_ESCAPE_MASK = 3'd3;
    localparam logic [2:0] CFG_CRC_POLY    = 3'd4;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    // One result transaction as it moves through the output stages
    typedef struct packed {
        t_event      event_res;
        logic [7:0]  pkt_address;
        logic [7:0]  pkt_command;
        logic [7:0]  pkt_key;
        logic [15:0] pkt_length;
        logic [7:0]  data_byte;
        logic [7:0]  data_index;
        logic        from_mem;   // data_byte comes from the store read port
    } t_result;

    // Reflected CRC-16, one byte, LSB first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b,
                                             input logic [15:0] poly);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ poly) : (c >> 1);
        end
        return c;
    endfunction

endpackage

### hdl/dle_stx_etx_packet_deframer_top.sv
// An accepted transaction is registered into stage 1 (s1), then into the output stage,
// where its result is held until the consumer takes it.
// Throughput: one transaction per cycle unless stalled; each gives one result.
// The loop is the unrolled 8-bit CRC update plus the phase transition, both combinational.
// Reset (synchronous, active low): block idle, config at defaults, header and CRC zero.
// The payload store is not cleared; no clearing pass, nothing is stalled after reset.
`timescale 1ns / 1ps

`include "dle_stx_etx_packet_deframer_top_macros.svh"

module dle_stx_etx_packet_deframer_top #(
    parameter int MAX_PAYLOAD = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    // Configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,

    // Request channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_req_type,
    input  logic [7:0]  i_rx_byte,
    input  logic [7:0]  i_read_index,

    // Result channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_event_res,
    output logic [7:0]  o_pkt_address,
    output logic [7:0]  o_pkt_command,
    output logic [7:0]  o_pkt_key,
    output logic [15:0] o_pkt_length,
    output logic [7:0]  o_data_byte,
    output logic [7:0]  o_data_index
);

    // Only the first 256 positions can ever be read back, so the store stops there.
    localparam int DEPTH = (MAX_PAYLOAD < 256) ? MAX_PAYLOAD : 256;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FW    = $clog2(MAX_PAYLOAD + 1);

    // ------------------------------------------------------------------
    // Configuration registers. Always ready; user must write only while idle, unchecked.
    // ------------------------------------------------------------------
    logic [7:0]  r_start_code;
    logic [7:0]  r_end_code;
    logic [7:0]  r_escape_code;
    logic [7:0]  r_escape_mask;
    logic [15:0] r_crc_poly;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_code  <= 8'h02;
            r_end_code    <= 8'h03;
            r_escape_code <= 8'h10;
            r_escape_mask <= 8'h20;
            r_crc_poly    <= 16'hA001;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                dle_dfr_pkg::CFG_START_CODE:  r_start_code  <= i_cfg_data[7:0];
                dle_dfr_pkg::CFG_END_CODE:    r_end_code    <= i_cfg_data[7:0];
                dle_dfr_pkg::CFG_ESCAPE_CODE: r_escape_code <= i_cfg_data[7:0];
                dle_dfr_pkg::CFG_ESCAPE_MASK: r_escape_mask <= i_cfg_data[7:0];
                dle_dfr_pkg::CFG_CRC_POLY:    r_crc_poly    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake. Stage 1 (s1) holds the result of the transaction just
    // taken, alongside the store read data; the output stage sits after it.
    // ------------------------------------------------------------------
    logic                 r_s1_valid;
    dle_dfr_pkg::t_result r_s1;
    logic                 r_out_valid;
    dle_dfr_pkg::t_result r_out;
    logic                 s1_adv;
    logic                 in_acc;

    assign s1_adv  = r_s1_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_s1_valid && r_out_valid && i_stall;
    assign in_acc  = i_valid && !o_stall;

    // ------------------------------------------------------------------
    // Parser state
    // ------------------------------------------------------------------
    dle_dfr_pkg::t_phase r_phase, n_phase;
    logic                r_esc_pending, n_esc_pending;
    logic [15:0]         r_crc, n_crc;
    logic [7:0]          r_hdr_address, n_hdr_address;
    logic [7:0]          r_hdr_command, n_hdr_command;
    logic [7:0]          r_hdr_key, n_hdr_key;
    logic [15:0]         r_hdr_length, n_hdr_length;
    logic [FW-1:0]       r_fill_count, n_fill_count;

    dle_dfr_pkg::t_result n_res;
    logic                 mem_we;
    logic                 mem_re;
    logic [AW-1:0]        mem_ra;

    logic [7:0]    b_eff;
    logic [15:0]   crc_upd;
    logic [15:0]   len_full;
    logic [FW-1:0] fill_inc;
    logic          rd_in_range;

    assign b_eff       = r_esc_pending ? (i_rx_byte ^ r_escape_mask) : i_rx_byte;
    assign crc_upd     = dle_dfr_pkg::crc_byte(r_crc, b_eff, r_crc_poly);
    assign len_full    = {r_hdr_length[15:8], b_eff};
    assign fill_inc    = r_fill_count + FW'(1);
    assign rd_in_range = {1'b0, i_read_index} < 9'(DEPTH);
    assign mem_ra      = i_read_index[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= dle_dfr_pkg::PH_IDLE;
            r_esc_pending <= 1'b0;
            r_crc         <= 16'h0000;
            r_hdr_address <= 8'h00;
            r_hdr_command <= 8'h00;
            r_hdr_key     <= 8'h00;
            r_hdr_length  <= 16'h0000;
            r_fill_count  <= '0;
        end else if (in_acc) begin
            r_phase       <= n_phase;
            r_esc_pending <= n_esc_pending;
            r_crc         <= n_crc;
            r_hdr_address <= n_hdr_address;
            r_hdr_command <= n_hdr_command;
            r_hdr_key     <= n_hdr_key;
            r_hdr_length  <= n_hdr_length;
            r_fill_count  <= n_fill_count;
        end
    end

    always_comb begin
        dle_dfr_pkg::t_event ev;
        logic [7:0]          dbyte;
        logic [7:0]          didx;
        logic                from_mem;

        n_phase       = r_phase;
        n_esc_pending = r_esc_pending;
        n_crc         = r_crc;
        n_hdr_address = r_hdr_address;
        n_hdr_command = r_hdr_command;
        n_hdr_key     = r_hdr_key;
        n_hdr_length  = r_hdr_length;
        n_fill_count  = r_fill_count;
        ev            = dle_dfr_pkg::EV_NONE;
        dbyte         = 8'h00;
        didx          = 8'h00;
        from_mem      = 1'b0;
        mem_we        = 1'b0;
        mem_re        = 1'b0;

        case (dle_dfr_pkg::t_req'(i_req_type))
            dle_dfr_pkg::REQ_BYTE: begin
                if (i_rx_byte == r_escape_code) begin
                    n_esc_pending = 1'b1;
                end else begin
                    n_esc_pending = 1'b0;
                    case (r_phase)
                        dle_dfr_pkg::PH_IDLE, dle_dfr_pkg::PH_DONE: ;
                        dle_dfr_pkg::PH_HUNT: begin
                            if (b_eff == r_start_code) begin
                                n_crc        = dle_dfr_pkg::CRC_INIT;
                                n_fill_count = '0;
                                n_phase      = dle_dfr_pkg::PH_ADDR;
                            end
                        end
                        dle_dfr_pkg::PH_ADDR: begin
                            n_hdr_address = b_eff;
                            n_crc         = crc_upd;
                            n_phase       = dle_dfr_pkg::PH_CMD;
                        end
                        dle_dfr_pkg::PH_CMD: begin
                            n_hdr_command = b_eff;
                            n_crc         = crc_upd;
                            n_phase       = dle_dfr_pkg::PH_KEY;
                        end
                        dle_dfr_pkg::PH_KEY: begin
                            n_hdr_key = b_eff;
                            n_crc     = crc_upd;
                            n_phase   = dle_dfr_pkg::PH_LENH;
                        end
                        dle_dfr_pkg::PH_LENH: begin
                            n_hdr_length = {b_eff, 8'h00};
                            n_crc        = crc_upd;
                            n_phase      = dle_dfr_pkg::PH_LENL;
                        end
                        dle_dfr_pkg::PH_LENL: begin
                            n_hdr_length = len_full;
                            n_crc        = crc_upd;
                            if ({1'b0, len_full} > 17'(MAX_PAYLOAD)) begin
                                ev      = dle_dfr_pkg::EV_LONG;
                                n_phase = dle_dfr_pkg::PH_HUNT;
                            end else if (len_full == 16'h0000) begin
                                n_phase = dle_dfr_pkg::PH_CRCL;
                            end else begin
                                n_phase = dle_dfr_pkg::PH_DATA;
                            end
                        end
                        dle_dfr_pkg::PH_DATA: begin
                            mem_we       = 17'(r_fill_count) < 17'(DEPTH);
                            dbyte        = b_eff;
                            didx         = 8'(r_fill_count);
                            ev           = dle_dfr_pkg::EV_STORED;
                            n_fill_count = fill_inc;
                            n_crc        = crc_upd;
                            if (16'(fill_inc) >= r_hdr_length) begin
                                n_phase = dle_dfr_pkg::PH_CRCL;
                            end
                        end
                        dle_dfr_pkg::PH_CRCL: begin
                            n_crc   = crc_upd;
                            n_phase = dle_dfr_pkg::PH_CRCH;
                        end
                        dle_dfr_pkg::PH_CRCH: begin
                            n_crc = crc_upd;
                            if (crc_upd == 16'h0000) begin
                                n_phase = dle_dfr_pkg::PH_END;
                            end else begin
                                ev      = dle_dfr_pkg::EV_CRC;
                                n_phase = dle_dfr_pkg::PH_HUNT;
                            end
                        end
                        dle_dfr_pkg::PH_END: begin
                            if (b_eff == r_end_code) begin
                                ev      = dle_dfr_pkg::EV_GOOD;
                                n_phase = dle_dfr_pkg::PH_DONE;
                            end else begin
                                ev      = dle_dfr_pkg::EV_NOEND;
                                n_phase = dle_dfr_pkg::PH_HUNT;
                            end
                        end
                        default: begin
                            ev      = dle_dfr_pkg::EV_BADSTATE;
                            n_phase = dle_dfr_pkg::PH_IDLE;
                        end
                    endcase
                end
            end
            dle_dfr_pkg::REQ_REARM: begin
                n_phase = dle_dfr_pkg::PH_HUNT;
            end
            dle_dfr_pkg::REQ_READ: begin
                ev       = dle_dfr_pkg::EV_READ;
                didx     = i_read_index;
                mem_re   = rd_in_range;
                from_mem = rd_in_range;
            end
            default: ;
        endcase

        n_res.event_res   = ev;
        n_res.pkt_address = n_hdr_address;
        n_res.pkt_command = n_hdr_command;
        n_res.pkt_key     = n_hdr_key;
        n_res.pkt_length  = n_hdr_length;
        n_res.data_byte   = dbyte;
        n_res.data_index  = didx;
        n_res.from_mem    = from_mem;
    end

    // ------------------------------------------------------------------
    // Payload store: one write port, one registered read port.
    // A write at one edge is visible to a read taken at the next, so no
    // bypass is needed. Read data only loads on a read transaction, so it
    // stays put while s1 is held.
    // ------------------------------------------------------------------
    logic [7:0] r_mem [0:DEPTH-1];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (in_acc && mem_we) begin
            r_mem[r_fill_count[AW-1:0]] <= b_eff;
        end
        if (in_acc && mem_re) begin
            r_rd_data <= r_mem[mem_ra];
        end
    end

    // ------------------------------------------------------------------
    // Result stages
    // ------------------------------------------------------------------
    dle_dfr_pkg::t_result s1_res;

    always_comb begin
        s1_res = r_s1;
        if (r_s1.from_mem) begin
            s1_res.data_byte = r_rd_data;
        end
        s1_res.from_mem = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1 <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out <= s1_res;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_event_res   = r_out.event_res;
    assign o_pkt_address = r_out.pkt_address;
    assign o_pkt_command = r_out.pkt_command;
    assign o_pkt_key     = r_out.pkt_key;
    assign o_pkt_length  = r_out.pkt_length;
    assign o_data_byte   = r_out.data_byte;
    assign o_data_index  = r_out.data_index;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    // store is only written while payload bytes are being collected
    `DLE_ASSERT_IMP(a_we_in_data, i_clk, i_rst_n, in_acc && mem_we,
        r_phase == dle_dfr_pkg::PH_DATA)
    // fill count stays below the declared length while collecting
    `DLE_ASSERT_IMP(a_fill_bound, i_clk, i_rst_n, r_phase == dle_dfr_pkg::PH_DATA,
        16'(r_fill_count) < r_hdr_length)
    // a held s1 must stall the request side
    `DLE_ASSERT_IMP(a_s1_hold_stalls, i_clk, i_rst_n, r_s1_valid && !s1_adv, o_stall)
    // a read transaction lands in s1 as a read result
    `DLE_ASSERT_NXT(a_read_to_s1, i_clk, i_rst_n,
        in_acc && i_req_type == dle_dfr_pkg::REQ_READ,
        r_s1_valid && r_s1.event_res == dle_dfr_pkg::EV_READ)

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int DEPTH       = 256;      // payload store size, matches the block's default
    localparam int CYCLE_LIMIT = 800000;   // generous: the slowest legal run is far below this
    localparam int PHASE_ITEMS = 20;       // random line items per half of each setting

    // ------------------------------------------------------------------
    // Clock, reset and block ports
    // ------------------------------------------------------------------
    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_cfg_valid  = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index  = '0;
    logic [15:0] i_cfg_data   = '0;
    logic        i_valid      = 1'b0;
    logic        o_stall;
    logic [1:0]  i_req_type   = '0;
    logic [7:0]  i_rx_byte    = '0;
    logic [7:0]  i_read_index = '0;
    logic        o_valid;
    logic        i_stall      = 1'b0;
    logic [2:0]  o_event_res;
    logic [7:0]  o_pkt_address;
    logic [7:0]  o_pkt_command;
    logic [7:0]  o_pkt_key;
    logic [15:0] o_pkt_length;
    logic [7:0]  o_data_byte;
    logic [7:0]  o_data_index;

    always #6 i_clk = ~i_clk;

    dle_stx_etx_packet_deframer_top #(
        .MAX_PAYLOAD(DEPTH)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_req_type   (i_req_type),
        .i_rx_byte    (i_rx_byte),
        .i_read_index (i_read_index),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_event_res  (o_event_res),
        .o_pkt_address(o_pkt_address),
        .o_pkt_command(o_pkt_command),
        .o_pkt_key    (o_pkt_key),
        .o_pkt_length (o_pkt_length),
        .o_data_byte  (o_data_byte),
        .o_data_index (o_data_index)
    );

    // ------------------------------------------------------------------
    // Types
    // ------------------------------------------------------------------
    // One request transaction on the line side
    typedef struct {
        dle_dfr_pkg::t_req req;
        logic [7:0]        rx;
        logic [7:0]        ridx;
    } t_line_item;

    // One predicted result transaction
    typedef struct packed {
        dle_dfr_pkg::t_event evt;
        logic [7:0]          addr;
        logic [7:0]          cmd;
        logic [7:0]          key;
        logic [15:0]         len;
        logic [7:0]          dbyte;
        logic [7:0]          didx;
    } t_frame_result;

    // Ways a generated packet can be spoilt
    typedef enum {FLT_NONE, FLT_CRC, FLT_NOEND, FLT_TRUNC} t_fault;

    // ------------------------------------------------------------------
    // Deframer prediction state and configuration copy
    // ------------------------------------------------------------------
    dle_dfr_pkg::t_phase ph;
    logic        esc_pend;
    logic [15:0] crc_acc;
    logic [7:0]  h_addr, h_cmd, h_key;
    logic [15:0] h_len;
    logic [8:0]  fill;
    logic [7:0]  store_mem [DEPTH];
    bit          written   [DEPTH];
    int          written_list[$];   // store positions that hold data, for safe read-back

    logic [7:0]  c_start, c_end, c_esc, c_mask;
    logic [15:0] c_poly;

    // Testbench bookkeeping
    t_line_item    line_q[$];       // requests waiting to be driven
    t_frame_result result_q[$];     // predicted results waiting for the block
    t_line_item    cur;             // request currently on the bus
    int            n_pushed   = 0;
    int            n_accepted = 0;
    int            n_stim     = 0;  // requests that do something (no-ops left out)
    int            err_count  = 0;
    int            gap_left   = 0;
    int            stall_left = 0;
    int            cycle_cnt  = 0;
    bit            quiet      = 1'b0;  // no idling on either side

    // Reflected CRC-16, LSB first; feedback taken bit by bit
    function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b,
                                             input logic [15:0] poly);
        logic [15:0] r;
        r = crc;
        for (int k = 0; k < 8; k++) begin
            if (r[0] ^ b[k]) begin
                r = (r >> 1) ^ poly;
            end else begin
                r = r >> 1;
            end
        end
        return r;
    endfunction

    task automatic pred_reset();
        ph       = dle_dfr_pkg::PH_IDLE;
        esc_pend = 1'b0;
        crc_acc  = '0;
        h_addr   = '0;
        h_cmd    = '0;
        h_key    = '0;
        h_len    = '0;
        fill     = '0;
        c_start  = 8'h02;
        c_end    = 8'h03;
        c_esc    = 8'h10;
        c_mask   = 8'h20;
        c_poly   = 16'hA001;
        for (int i = 0; i < DEPTH; i++) begin
            written[i] = 1'b0;
        end
        written_list.delete();
    endtask

    // Advance the prediction by one accepted request
    function automatic t_frame_result deframe_step(input dle_dfr_pkg::t_req req,
                                                   input logic [7:0] rx,
                                                   input logic [7:0] ridx);
        t_frame_result r;
        logic [7:0]    b;
        r = '0;
        r.evt = dle_dfr_pkg::EV_NONE;
        case (req)
            dle_dfr_pkg::REQ_BYTE: begin
                if (rx == c_esc) begin
                    esc_pend = 1'b1;   // marker dropped; a repeat keeps it pending
                end else begin
                    b = rx;
                    if (esc_pend) begin
                        b = rx ^ c_mask;
                        esc_pend = 1'b0;
                    end
                    case (ph)
                        dle_dfr_pkg::PH_IDLE, dle_dfr_pkg::PH_DONE: ;
                        dle_dfr_pkg::PH_HUNT: begin
                            if (b == c_start) begin
                                crc_acc = dle_dfr_pkg::CRC_INIT;
                                fill    = '0;
                                ph      = dle_dfr_pkg::PH_ADDR;
                            end
                        end
                        dle_dfr_pkg::PH_ADDR: begin
                            h_addr  = b;
                            crc_acc = crc_step(crc_acc, b, c_poly);
                            ph      = dle_dfr_pkg::PH_CMD;
                        end
                        dle_dfr_pkg::PH_CMD: begin
                            h_cmd   = b;
                            crc_acc = crc_step(crc_acc, b, c_poly);
                            ph      = dle_dfr_pkg::PH_KEY;
                        end
                        dle_dfr_pkg::PH_KEY: begin
                            h_key   = b;
                            crc_acc = crc_step(crc_acc, b, c_poly);
                            ph      = dle_dfr_pkg::PH_LENH;
                        end
                        dle_dfr_pkg::PH_LENH: begin
                            h_len   = {b, 8'h00};
                            crc_acc = crc_step(crc_acc, b, c_poly);
                            ph      = dle_dfr_pkg::PH_LENL;
                        end
                        dle_dfr_pkg::PH_LENL: begin
                            h_len   = {h_len[15:8], b};
                            crc_acc = crc_step(crc_acc, b, c_poly);
                            if (h_len > DEPTH) begin
                                r.evt = dle_dfr_pkg::EV_LONG;
                                ph    = dle_dfr_pkg::PH_HUNT;
                            end else if (h_len == 0) begin
                                ph = dle_dfr_pkg::PH_CRCL;
                            end else begin
                                ph = dle_dfr_pkg::PH_DATA;
                            end
                        end
                        dle_dfr_pkg::PH_DATA: begin
                            store_mem[fill[7:0]] = b;
                            if (!written[fill[7:0]]) begin
                                written[fill[7:0]] = 1'b1;
                                written_list.push_back(int'(fill[7:0]));
                            end
                            r.evt   = dle_dfr_pkg::EV_STORED;
                            r.dbyte = b;
                            r.didx  = fill[7:0];
                            fill    = fill + 9'd1;
                            crc_acc = crc_step(crc_acc, b, c_poly);
                            if (fill >= h_len) begin
                                ph = dle_dfr_pkg::PH_CRCL;
                            end
                        end
                        dle_dfr_pkg::PH_CRCL: begin
                            crc_acc = crc_step(crc_acc, b, c_poly);
                            ph      = dle_dfr_pkg::PH_CRCH;
                        end
                        dle_dfr_pkg::PH_CRCH: begin
                            crc_acc = crc_step(crc_acc, b, c_poly);
                            if (crc_acc == 16'h0000) begin
                                ph = dle_dfr_pkg::PH_END;
                            end else begin
                                r.evt = dle_dfr_pkg::EV_CRC;
                                ph    = dle_dfr_pkg::PH_HUNT;
                            end
                        end
                        dle_dfr_pkg::PH_END: begin
                            if (b == c_end) begin
                                r.evt = dle_dfr_pkg::EV_GOOD;
                                ph    = dle_dfr_pkg::PH_DONE;
                            end else begin
                                r.evt = dle_dfr_pkg::EV_NOEND;
                                ph    = dle_dfr_pkg::PH_HUNT;
                            end
                        end
                        default: begin
                            r.evt = dle_dfr_pkg::EV_BADSTATE;
                            ph    = dle_dfr_pkg::PH_IDLE;
                        end
                    endcase
                end
            end
            dle_dfr_pkg::REQ_REARM: ph = dle_dfr_pkg::PH_HUNT;
            dle_dfr_pkg::REQ_READ: begin
                r.evt   = dle_dfr_pkg::EV_READ;
                r.didx  = ridx;
                r.dbyte = store_mem[ridx];
            end
            default: ;
        endcase
        r.addr = h_addr;
        r.cmd  = h_cmd;
        r.key  = h_key;
        r.len  = h_len;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Idle lengths: mostly none or short, now and then long
    // ------------------------------------------------------------------
    function automatic int pick_idle();
        int r;
        if (quiet) begin
            return 0;
        end
        r = int'($urandom_range(0, 99));
        if (r < 60) return 0;
        if (r < 88) return int'($urandom_range(1, 3));
        if (r < 97) return int'($urandom_range(4, 12));
        return int'($urandom_range(20, 60));
    endfunction

    task automatic report_err(input string what, input int got, input int want);
        if (err_count < 50) begin
            $display("tb_top: mismatch on %s: got %0h, want %0h (cycle %0d)",
                     what, got, want, cycle_cnt);
        end
        err_count++;
    endtask

    // ------------------------------------------------------------------
    // Driver: one request transaction per slot, predicted on acceptance
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                result_q.push_back(deframe_step(cur.req, cur.rx, cur.ridx));
                n_accepted++;
            end
            if (!i_valid || !o_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (line_q.size() > 0) begin
                    cur = line_q.pop_front();
                    // prediction is up to date here, so steer reads onto written entries
                    if (cur.req == dle_dfr_pkg::REQ_READ && !written[cur.ridx]) begin
                        if (written_list.size() > 0) begin
                            cur.ridx = 8'(written_list[$urandom_range(0,
                                                      written_list.size() - 1)]);
                        end else begin
                            cur.req = dle_dfr_pkg::REQ_NOP;
                        end
                    end
                    i_valid      <= 1'b1;
                    i_req_type   <= cur.req;
                    i_rx_byte    <= cur.rx;
                    i_read_index <= cur.ridx;
                    gap_left = pick_idle();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: random back-pressure, compare against the oldest prediction
    // ------------------------------------------------------------------
    task automatic check_result();
        t_frame_result w;
        if (result_q.size() == 0) begin
            report_err("result with nothing expected", int'(o_event_res), 0);
            return;
        end
        w = result_q.pop_front();
        if (o_event_res !== w.evt)
            report_err("event_res", int'(o_event_res), int'(w.evt));
        if (o_pkt_address !== w.addr)
            report_err("pkt_address", int'(o_pkt_address), int'(w.addr));
        if (o_pkt_command !== w.cmd)
            report_err("pkt_command", int'(o_pkt_command), int'(w.cmd));
        if (o_pkt_key !== w.key)
            report_err("pkt_key", int'(o_pkt_key), int'(w.key));
        if (o_pkt_length !== w.len)
            report_err("pkt_length", int'(o_pkt_length), int'(w.len));
        if (o_data_byte !== w.dbyte)
            report_err("data_byte", int'(o_data_byte), int'(w.dbyte));
        if (o_data_index !== w.didx)
            report_err("data_index", int'(o_data_index), int'(w.didx));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                check_result();
            end
            if (stall_left > 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else begin
                stall_left = pick_idle();
                if (stall_left > 0) begin
                    stall_left--;
                    i_stall <= 1'b1;
                end else begin
                    i_stall <= 1'b0;
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_item(input dle_dfr_pkg::t_req req, input logic [7:0] rx,
                             input logic [7:0] ridx);
        t_line_item it;
        it.req  = req;
        it.rx   = rx;
        it.ridx = ridx;
        line_q.push_back(it);
        n_pushed++;
        if (req != dle_dfr_pkg::REQ_NOP) begin
            n_stim++;
        end
    endtask

    task automatic push_byte(input logic [7:0] b);
        push_item(dle_dfr_pkg::REQ_BYTE, b, 8'($urandom()));
    endtask

    // Send one decoded byte, stuffing it where it collides with the escape code
    // and now and then at random. With a zero mask the escape value cannot be sent.
    task automatic send_dec(input logic [7:0] b);
        logic [7:0] e;
        e = b ^ c_mask;
        if ((b == c_esc || $urandom_range(0, 7) == 0) && e != c_esc) begin
            push_byte(c_esc);
            push_byte(e);
        end else begin
            push_byte(b);
        end
    endtask

    function automatic logic [7:0] rnd_data();
        logic [7:0] b;
        do b = 8'($urandom()); while (b == c_esc && c_mask == 8'h00);
        return b;
    endfunction

    function automatic logic [15:0] pick_len();
        int r;
        r = int'($urandom_range(0, 99));
        if (r < 65) return 16'($urandom_range(0, 6));
        if (r < 85) return 16'($urandom_range(7, 40));
        if (r < 90) return 16'($urandom_range(41, 100));
        if (r < 94) return 16'd257;      // one past the store
        if (r < 97) return 16'hFFFF;
        return 16'($urandom_range(258, 65535));
    endfunction

    function automatic t_fault pick_fault();
        int r;
        r = int'($urandom_range(0, 99));
        if (r < 65) return FLT_NONE;
        if (r < 77) return FLT_CRC;
        if (r < 89) return FLT_NOEND;
        return FLT_TRUNC;
    endfunction

    // Clear any pending escape, rearm, then frame one packet
    task automatic send_packet(input logic [7:0] addr, input logic [7:0] cmd,
                               input logic [7:0] key, input logic [15:0] len,
                               input t_fault flt);
        logic [15:0] crc;
        logic [7:0]  hdr[5];
        logic [7:0]  d, lo, hi, f;
        int          n;
        do f = 8'($urandom()); while (f == c_esc);
        push_byte(f);
        push_item(dle_dfr_pkg::REQ_REARM, 8'($urandom()), 8'($urandom()));
        send_dec(c_start);
        hdr[0] = addr;
        hdr[1] = cmd;
        hdr[2] = key;
        hdr[3] = len[15:8];
        hdr[4] = len[7:0];
        crc = dle_dfr_pkg::CRC_INIT;
        for (int i = 0; i < 5; i++) begin
            send_dec(hdr[i]);
            crc = crc_step(crc, hdr[i], c_poly);
        end
        if (len > DEPTH) begin
            return;
        end
        n = (flt == FLT_TRUNC) ? int'(len) / 2 : int'(len);
        for (int i = 0; i < n; i++) begin
            d = rnd_data();
            send_dec(d);
            crc = crc_step(crc, d, c_poly);
        end
        if (flt == FLT_TRUNC) begin
            return;
        end
        lo = crc[7:0];
        hi = crc[15:8];
        if (flt == FLT_CRC) begin
            lo = lo ^ (8'h01 << $urandom_range(0, 7));
        end
        send_dec(lo);
        send_dec(hi);
        if (flt == FLT_NOEND) begin
            send_dec(c_end ^ 8'($urandom_range(1, 255)));
        end else begin
            send_dec(c_end);
        end
    endtask

    task automatic send_reads(input int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 1) == 0) begin
                push_item(dle_dfr_pkg::REQ_READ, 8'($urandom()), 8'($urandom_range(0, 7)));
            end else begin
                push_item(dle_dfr_pkg::REQ_READ, 8'($urandom()), 8'($urandom_range(0, 255)));
            end
        end
    endtask

    // Loose traffic: stray bytes (often the special codes), rearms, reads, no-ops
    task automatic send_noise(input int n);
        int r;
        for (int i = 0; i < n; i++) begin
            r = int'($urandom_range(0, 99));
            if (r < 15) begin
                case ($urandom_range(0, 2))
                    0: push_byte(c_start);
                    1: push_byte(c_esc);
                    default: push_byte(c_end);
                endcase
            end else if (r < 50) begin
                push_byte(8'($urandom()));
            end else if (r < 65) begin
                push_item(dle_dfr_pkg::REQ_REARM, 8'($urandom()), 8'($urandom()));
            end else if (r < 80) begin
                push_item(dle_dfr_pkg::REQ_READ, 8'($urandom()), 8'($urandom()));
            end else begin
                push_item(dle_dfr_pkg::REQ_NOP, 8'($urandom()), 8'($urandom()));
            end
        end
    endtask

    task automatic run_random(input int n);
        int first;
        int r;
        first = n_stim;
        while (n_stim - first < n) begin
            r = int'($urandom_range(0, 99));
            if (r < 72) begin
                send_packet(rnd_data(), rnd_data(), rnd_data(), pick_len(), pick_fault());
            end else if (r < 86) begin
                send_reads(int'($urandom_range(1, 6)));
            end else begin
                send_noise(int'($urandom_range(1, 8)));
            end
        end
    endtask

    // Returns at a rising edge once every request is in and every result is out
    task automatic wait_drained();
        do @(posedge i_clk); while (!(n_accepted == n_pushed && result_q.size() == 0));
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [15:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            dle_dfr_pkg::CFG_START_CODE:  c_start = val[7:0];
            dle_dfr_pkg::CFG_END_CODE:    c_end   = val[7:0];
            dle_dfr_pkg::CFG_ESCAPE_CODE: c_esc   = val[7:0];
            dle_dfr_pkg::CFG_ESCAPE_MASK: c_mask  = val[7:0];
            dle_dfr_pkg::CFG_CRC_POLY:    c_poly  = val;
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic [7:0] s, input logic [7:0] e,
                                  input logic [7:0] x, input logic [7:0] m,
                                  input logic [15:0] p);
        cfg_write(dle_dfr_pkg::CFG_START_CODE,  {8'h00, s});
        cfg_write(dle_dfr_pkg::CFG_END_CODE,    {8'h00, e});
        cfg_write(dle_dfr_pkg::CFG_ESCAPE_CODE, {8'h00, x});
        cfg_write(dle_dfr_pkg::CFG_ESCAPE_MASK, {8'h00, m});
        cfg_write(dle_dfr_pkg::CFG_CRC_POLY,    p);
        i_cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        pred_reset();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait_drained();

        // directed, reset settings: idle bytes, no-op, double escape, zero-length
        // packet, over-long length, then a read with nothing stored, sent as a no-op
        push_byte(8'h00);
        push_item(dle_dfr_pkg::REQ_NOP, 8'hFF, 8'hFF);
        push_byte(c_esc);
        push_byte(c_esc);
        push_byte(8'h41);
        send_packet(8'hFF, 8'h00, 8'h5A, 16'd0, FLT_NONE);
        send_packet(8'h00, 8'hFF, 8'hC3, 16'hFFFF, FLT_NONE);
        push_item(dle_dfr_pkg::REQ_READ, 8'h00, 8'h00);
        wait_drained();

        for (int p = 0; p < 5; p++) begin
            case (p)
                1: apply_settings(8'h00, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF);
                2: apply_settings(8'hFF, 8'h7E, 8'h00, 8'h00, 16'h0000);
                3: apply_settings(8'($urandom()), 8'($urandom()), 8'($urandom()),
                                  8'($urandom_range(1, 255)), 16'($urandom()));
                4: apply_settings(8'h02, 8'h03, 8'h10, 8'h20, 16'h8408);
                default: ;
            endcase
            quiet = (p == 3);
            if (p == 0) begin
                // fill the whole store once, then read back its ends
                send_packet(rnd_data(), rnd_data(), rnd_data(), 16'd256, FLT_NONE);
                push_item(dle_dfr_pkg::REQ_READ, 8'h00, 8'hFF);
                push_item(dle_dfr_pkg::REQ_READ, 8'h00, 8'h00);
                send_reads(8);
            end
            run_random(PHASE_ITEMS);
            // sender holds off until the block has answered everything
            wait_drained();
            run_random(PHASE_ITEMS);
            wait_drained();
        end

        // allow for the pipeline, in case something arrives late
        repeat (10) @(posedge i_clk);
        if (err_count == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
